// ===== hdl/tqm_pkg.sv =====
// Package for the ordered timer queue: opcodes, result kinds, controller states
// and the command and status words between the controller and the datapath.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package tqm_pkg;

   localparam int SLOTS_DEFAULT     = 64;
   localparam int TIME_BITS_DEFAULT = 48;
   localparam int RESULT_CAP        = 64;
   localparam int TIME_FIELD_W      = 48;
   localparam int SLOT_FIELD_W      = 6;
   localparam int SEQ_W             = 32;
   localparam int KIND_W            = 3;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_CANCEL = 2'd1,
      OP_TICK   = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   localparam logic [KIND_W-1:0] KIND_ADDED     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_FULL      = 3'd1;
   localparam logic [KIND_W-1:0] KIND_CANCELLED = 3'd2;
   localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd3;
   localparam logic [KIND_W-1:0] KIND_EXPIRED   = 3'd4;
   localparam logic [KIND_W-1:0] KIND_NOTHING   = 3'd5;

   typedef enum logic [1:0] {
      SCAN_EARLIEST,
      SCAN_DUE,
      SCAN_MARK
   } scan_mode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADD_SCAN,
      ST_ADD_DO,
      ST_CAN_READ,
      ST_CAN_CHECK,
      ST_MARK_SCAN,
      ST_PICK_SCAN,
      ST_PICK_CHECK,
      ST_PICK_READ,
      ST_PICK_UPDATE,
      ST_FIN_SCAN,
      ST_FIN_LATCH,
      ST_OUT_ONE,
      ST_EMIT_A,
      ST_EMIT_B,
      ST_EMIT_C
   } state_type;

   typedef struct packed {
      logic          capture;
      logic          scan_start;
      scan_mode_type scan_mode;
      logic          add_commit;
      logic          cancel_commit;
      logic          pick_commit;
      logic          fin_latch;
      logic          emit_addr;
      logic          out_single;
      logic          out_emit;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic best_vld;
      logic cnt_zero;
      logic cnt_full;
      logic emit_last;
      logic op_tick;
   } status_type;

endpackage

// ===== hdl/tqm_ctrl.sv =====
// Controller of the timer queue: sequences scans, commits and result words.
// Depends on tqm_pkg; drives the datapath only through cmd_type and status_type.
`timescale 1ns / 1ps

module tqm_ctrl
   import tqm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] req_opcode,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.scan_mode = SCAN_EARLIEST;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (opcode_type'(req_opcode))
                  OP_ADD: begin
                     cmd.capture    = 1'b1;
                     cmd.scan_start = 1'b1;
                     state_in       = ST_ADD_SCAN;
                  end
                  OP_CANCEL: begin
                     cmd.capture = 1'b1;
                     state_in    = ST_CAN_READ;
                  end
                  OP_TICK: begin
                     cmd.capture    = 1'b1;
                     cmd.scan_start = 1'b1;
                     cmd.scan_mode  = SCAN_MARK;
                     state_in       = ST_MARK_SCAN;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_ADD_SCAN: begin
            if (status.scan_done) state_in = ST_ADD_DO;
         end
         ST_ADD_DO: begin
            cmd.add_commit = 1'b1;
            state_in       = ST_OUT_ONE;
         end
         ST_CAN_READ: state_in = ST_CAN_CHECK;
         ST_CAN_CHECK: begin
            cmd.cancel_commit = 1'b1;
            cmd.scan_start    = 1'b1;
            state_in          = ST_FIN_SCAN;
         end
         ST_MARK_SCAN: begin
            if (status.scan_done) begin
               cmd.scan_start = 1'b1;
               cmd.scan_mode  = SCAN_DUE;
               state_in       = ST_PICK_SCAN;
            end
         end
         ST_PICK_SCAN: begin
            if (status.scan_done) state_in = ST_PICK_CHECK;
         end
         ST_PICK_CHECK: begin
            if (status.best_vld && !status.cnt_full) begin
               state_in = ST_PICK_READ;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = ST_FIN_SCAN;
            end
         end
         ST_PICK_READ: state_in = ST_PICK_UPDATE;
         ST_PICK_UPDATE: begin
            cmd.pick_commit = 1'b1;
            cmd.scan_start  = 1'b1;
            cmd.scan_mode   = SCAN_DUE;
            state_in        = ST_PICK_SCAN;
         end
         ST_FIN_SCAN: begin
            if (status.scan_done) state_in = ST_FIN_LATCH;
         end
         ST_FIN_LATCH: begin
            cmd.fin_latch = 1'b1;
            if (status.op_tick && !status.cnt_zero) state_in = ST_EMIT_A;
            else state_in = ST_OUT_ONE;
         end
         ST_OUT_ONE: begin
            cmd.out_single = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_EMIT_A: state_in = ST_EMIT_B;
         ST_EMIT_B: begin
            cmd.emit_addr = 1'b1;
            state_in      = ST_EMIT_C;
         end
         ST_EMIT_C: begin
            cmd.out_emit = 1'b1;
            if (status.emit_last) state_in = ST_IDLE;
            else state_in = ST_EMIT_A;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== hdl/tqm_datapath.sv =====
// Datapath of the timer queue: timer memories, active and due bits, the slot
// scanner, the pick buffer and the result word registers.
// Depends on tqm_pkg; controlled by tqm_ctrl through cmd_type and status_type.
`timescale 1ns / 1ps

module tqm_datapath
   import tqm_pkg::*;
#(
   parameter int SLOTS     = SLOTS_DEFAULT,
   parameter int TIME_BITS = TIME_BITS_DEFAULT
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output status_type              status,
   input  logic [1:0]              req_opcode,
   input  logic [SLOT_FIELD_W-1:0] req_cancel_slot,
   input  logic [SEQ_W-1:0]        req_cancel_sequence,
   input  logic [TIME_FIELD_W-1:0] req_expire_at,
   input  logic [TIME_FIELD_W-1:0] req_repeat_interval,
   input  logic [TIME_FIELD_W-1:0] req_now_time,
   output logic                    rsp_strobe,
   output logic [KIND_W-1:0]       rsp_result_kind,
   output logic [SLOT_FIELD_W-1:0] rsp_slot_number,
   output logic [SEQ_W-1:0]        rsp_sequence_number,
   output logic                    rsp_last,
   output logic                    rsp_rearm,
   output logic [TIME_FIELD_W-1:0] rsp_next_deadline,
   output logic                    rsp_deadline_valid
);

   localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SW   = (IDXW > SLOT_FIELD_W) ? IDXW : SLOT_FIELD_W;
   localparam int WW   = (TIME_BITS > TIME_FIELD_W) ? TIME_BITS : TIME_FIELD_W;
   localparam int BUFW = $clog2(RESULT_CAP);
   localparam int CNTW = $clog2(RESULT_CAP + 1);

   logic [TIME_BITS-1:0] expiry_mem [SLOTS];
   logic [TIME_BITS-1:0] reload_mem [SLOTS];
   logic [SEQ_W-1:0]     seq_mem    [SLOTS];
   logic [IDXW-1:0]      pick_mem   [RESULT_CAP];

   logic [SLOTS-1:0]     active_ff;
   logic [SLOTS-1:0]     due_ff;
   logic [SEQ_W-1:0]     next_seq_ff;

   opcode_type              op_ff;
   logic [SLOT_FIELD_W-1:0] cslot_ff;
   logic [SEQ_W-1:0]        cseq_ff;
   logic [TIME_BITS-1:0]    when_ff, intv_ff, now_ff;

   logic                 issuing_ff, rd_vld_ff;
   logic [IDXW-1:0]      scan_idx_ff, rd_idx_ff;
   scan_mode_type        mode_ff;
   logic                 act_rd_ff, due_rd_ff;
   logic [TIME_BITS-1:0] exp_rd_ff, rel_rd_ff;
   logic [SEQ_W-1:0]     seq_rd_ff;
   logic                 best_vld_ff, free_vld_ff;
   logic [TIME_BITS-1:0] best_time_ff;
   logic [IDXW-1:0]      best_idx_ff, free_idx_ff;

   logic [CNTW-1:0]      cnt_ff;
   logic [BUFW-1:0]      emit_idx_ff;
   logic [IDXW-1:0]      pick_rd_ff;

   logic [KIND_W-1:0]       kind_ff;
   logic [SLOT_FIELD_W-1:0] slot_ff;
   logic [SEQ_W-1:0]        seqr_ff;
   logic                    rearm_ff, dl_vld_ff;
   logic [TIME_BITS-1:0]    dl_time_ff;

   logic                    strobe_ff;
   logic [KIND_W-1:0]       kind_o_ff;
   logic [SLOT_FIELD_W-1:0] slot_o_ff;
   logic [SEQ_W-1:0]        seq_o_ff;
   logic                    last_o_ff, rearm_o_ff, dlv_o_ff;
   logic [TIME_BITS-1:0]    dlt_o_ff;

   logic [WW-1:0]        when_w, intv_w, now_w;
   logic [SW-1:0]        cslot_w, free_w, pick_w;
   logic [IDXW-1:0]      caddr, rd_addr;
   logic                 in_range, hit, cand, better;
   logic [TIME_BITS:0]   sum;
   logic [TIME_BITS-1:0] reload_val;
   logic                 wr_en;
   logic [IDXW-1:0]      wr_addr;
   logic [TIME_BITS-1:0] wr_data;
   logic                 emit_last;
   logic [WW-1:0]        dlt_o_w;

   assign when_w  = WW'(req_expire_at);
   assign intv_w  = WW'(req_repeat_interval);
   assign now_w   = WW'(req_now_time);
   assign cslot_w = SW'(cslot_ff);
   assign free_w  = SW'(free_idx_ff);
   assign pick_w  = SW'(pick_rd_ff);
   assign caddr   = cslot_w[IDXW-1:0];
   assign in_range = (int'(cslot_ff) < SLOTS);
   assign hit = in_range && active_ff[caddr] && (seq_rd_ff == cseq_ff);

   always_comb begin
      if (issuing_ff) rd_addr = scan_idx_ff;
      else if (cmd.emit_addr) rd_addr = pick_rd_ff;
      else if (op_ff == OP_CANCEL) rd_addr = caddr;
      else rd_addr = best_idx_ff;
   end

   always_comb begin
      case (mode_ff)
         SCAN_DUE: cand = due_rd_ff;
         default:  cand = act_rd_ff;
      endcase
   end
   assign better = rd_vld_ff && (mode_ff != SCAN_MARK) && cand
                   && (!best_vld_ff || (exp_rd_ff < best_time_ff));

   assign sum        = {1'b0, now_ff} + {1'b0, rel_rd_ff};
   assign reload_val = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = free_idx_ff;
      wr_data = when_ff;
      if (cmd.add_commit && free_vld_ff) begin
         wr_en = 1'b1;
      end else if (cmd.pick_commit && (rel_rd_ff != '0)) begin
         wr_en   = 1'b1;
         wr_addr = best_idx_ff;
         wr_data = reload_val;
      end
   end

   assign emit_last = ((CNTW'(emit_idx_ff) + CNTW'(1)) == cnt_ff);

   always_ff @(posedge clock) begin
      if (wr_en) expiry_mem[wr_addr] <= wr_data;
      if (cmd.add_commit && free_vld_ff) begin
         reload_mem[free_idx_ff] <= intv_ff;
         seq_mem[free_idx_ff]    <= next_seq_ff;
      end
      if (cmd.pick_commit) pick_mem[cnt_ff[BUFW-1:0]] <= best_idx_ff;
      exp_rd_ff  <= expiry_mem[rd_addr];
      rel_rd_ff  <= reload_mem[rd_addr];
      seq_rd_ff  <= seq_mem[rd_addr];
      act_rd_ff  <= active_ff[rd_addr];
      due_rd_ff  <= due_ff[rd_addr];
      pick_rd_ff <= pick_mem[emit_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= '0;
         next_seq_ff <= '0;
         issuing_ff  <= 1'b0;
         rd_vld_ff   <= 1'b0;
         strobe_ff   <= 1'b0;
         best_vld_ff <= 1'b0;
         free_vld_ff <= 1'b0;
         cnt_ff      <= '0;
         emit_idx_ff <= '0;
         op_ff       <= OP_NONE;
         mode_ff     <= SCAN_EARLIEST;
      end else begin
         strobe_ff <= cmd.out_single || cmd.out_emit;
         rd_vld_ff <= issuing_ff;
         rd_idx_ff <= scan_idx_ff;
         if (cmd.capture) begin
            op_ff       <= opcode_type'(req_opcode);
            cnt_ff      <= '0;
            emit_idx_ff <= '0;
         end
         if (cmd.scan_start) begin
            issuing_ff  <= 1'b1;
            scan_idx_ff <= '0;
            mode_ff     <= cmd.scan_mode;
            best_vld_ff <= 1'b0;
            free_vld_ff <= 1'b0;
         end else if (issuing_ff) begin
            scan_idx_ff <= scan_idx_ff + IDXW'(1);
            if (scan_idx_ff == IDXW'(SLOTS - 1)) issuing_ff <= 1'b0;
         end
         if (better) begin
            best_vld_ff  <= 1'b1;
            best_time_ff <= exp_rd_ff;
            best_idx_ff  <= rd_idx_ff;
         end
         if (rd_vld_ff && (mode_ff == SCAN_EARLIEST) && !act_rd_ff && !free_vld_ff) begin
            free_vld_ff <= 1'b1;
            free_idx_ff <= rd_idx_ff;
         end
         if (rd_vld_ff && (mode_ff == SCAN_MARK)) begin
            due_ff[rd_idx_ff] <= act_rd_ff && (exp_rd_ff <= now_ff);
         end
         if (cmd.add_commit && free_vld_ff) begin
            active_ff[free_idx_ff] <= 1'b1;
            next_seq_ff            <= next_seq_ff + SEQ_W'(1);
         end
         if (cmd.cancel_commit && hit) active_ff[caddr] <= 1'b0;
         if (cmd.pick_commit) begin
            due_ff[best_idx_ff] <= 1'b0;
            cnt_ff              <= cnt_ff + CNTW'(1);
            if (rel_rd_ff == '0) active_ff[best_idx_ff] <= 1'b0;
         end
         if (cmd.out_emit) emit_idx_ff <= emit_idx_ff + BUFW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cslot_ff <= req_cancel_slot;
         cseq_ff  <= req_cancel_sequence;
         when_ff  <= when_w[TIME_BITS-1:0];
         intv_ff  <= intv_w[TIME_BITS-1:0];
         now_ff   <= now_w[TIME_BITS-1:0];
      end
      if (cmd.add_commit) begin
         if (free_vld_ff) begin
            kind_ff   <= KIND_ADDED;
            slot_ff   <= free_w[SLOT_FIELD_W-1:0];
            seqr_ff   <= next_seq_ff;
            rearm_ff  <= !best_vld_ff || (when_ff < best_time_ff);
            dl_vld_ff <= 1'b1;
            dl_time_ff <= (best_vld_ff && (best_time_ff < when_ff)) ? best_time_ff : when_ff;
         end else begin
            kind_ff    <= KIND_FULL;
            slot_ff    <= '0;
            seqr_ff    <= '0;
            rearm_ff   <= 1'b0;
            dl_vld_ff  <= best_vld_ff;
            dl_time_ff <= best_vld_ff ? best_time_ff : '0;
         end
      end
      if (cmd.cancel_commit) begin
         kind_ff <= hit ? KIND_CANCELLED : KIND_NOT_FOUND;
         slot_ff <= cslot_ff;
         seqr_ff <= cseq_ff;
      end
      if (cmd.fin_latch) begin
         rearm_ff   <= (op_ff == OP_TICK) && best_vld_ff;
         dl_vld_ff  <= best_vld_ff;
         dl_time_ff <= best_vld_ff ? best_time_ff : '0;
         if (op_ff == OP_TICK) begin
            kind_ff <= KIND_NOTHING;
            slot_ff <= '0;
            seqr_ff <= '0;
         end
      end
      if (cmd.out_single) begin
         kind_o_ff  <= kind_ff;
         slot_o_ff  <= slot_ff;
         seq_o_ff   <= seqr_ff;
         last_o_ff  <= 1'b1;
         rearm_o_ff <= rearm_ff;
         dlv_o_ff   <= dl_vld_ff;
         dlt_o_ff   <= dl_time_ff;
      end else if (cmd.out_emit) begin
         kind_o_ff  <= KIND_EXPIRED;
         slot_o_ff  <= pick_w[SLOT_FIELD_W-1:0];
         seq_o_ff   <= seq_rd_ff;
         last_o_ff  <= emit_last;
         rearm_o_ff <= rearm_ff;
         dlv_o_ff   <= dl_vld_ff;
         dlt_o_ff   <= dl_time_ff;
      end
   end

   assign status.scan_done = rd_vld_ff && (rd_idx_ff == IDXW'(SLOTS - 1));
   assign status.best_vld  = best_vld_ff;
   assign status.cnt_zero  = (cnt_ff == '0);
   assign status.cnt_full  = (cnt_ff == CNTW'(RESULT_CAP));
   assign status.emit_last = emit_last;
   assign status.op_tick   = (op_ff == OP_TICK);

   assign rsp_strobe         = strobe_ff;
   assign rsp_result_kind    = kind_o_ff;
   assign rsp_slot_number    = slot_o_ff;
   assign rsp_sequence_number = seq_o_ff;
   assign rsp_last           = last_o_ff;
   assign rsp_rearm          = rearm_o_ff;
   assign rsp_deadline_valid = dlv_o_ff;

   assign dlt_o_w           = WW'(dlt_o_ff);
   assign rsp_next_deadline = dlt_o_w[TIME_FIELD_W-1:0];

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNTW'(RESULT_CAP))
      else $error("pick count beyond the result cap");

   a_scan_feeds: assert property (@(posedge clock) disable iff (reset)
      issuing_ff |=> rd_vld_ff)
      else $error("scan issue not followed by read data");

   a_add_sets: assert property (@(posedge clock) disable iff (reset)
      (cmd.add_commit && free_vld_ff) |=> active_ff[$past(free_idx_ff)])
      else $error("added slot not marked active");

   a_no_deadline: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && !dlv_o_ff) |-> (dlt_o_ff == '0))
      else $error("deadline shown without a pending timer");

   a_due_scan_active: assert property (@(posedge clock) disable iff (reset)
      (rd_vld_ff && (mode_ff == SCAN_DUE) && due_rd_ff) |-> act_rd_ff)
      else $error("due slot found inactive");

endmodule

// ===== hdl/timer_queue_manager.sv =====
// Ordered timer queue. Each add, cancel and tick scans every slot, the scanner reading one
// slot per cycle; a tick runs one more scan of the slots for each timer that is due.
// One item at a time: busy is high from acceptance until the last result word.
// Result words appear one per strobe and cannot be stalled by the receiver.
// Synchronous reset clears all timers and the sequence counter.
`timescale 1ns / 1ps

module timer_queue_manager
   import tqm_pkg::*;
#(
   parameter int SLOTS     = SLOTS_DEFAULT,
   parameter int TIME_BITS = TIME_BITS_DEFAULT
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [1:0]              req_opcode,
   input  logic [SLOT_FIELD_W-1:0] req_cancel_slot,
   input  logic [SEQ_W-1:0]        req_cancel_sequence,
   input  logic [TIME_FIELD_W-1:0] req_expire_at,
   input  logic [TIME_FIELD_W-1:0] req_repeat_interval,
   input  logic [TIME_FIELD_W-1:0] req_now_time,
   output logic                    rsp_strobe,
   output logic [KIND_W-1:0]       rsp_result_kind,
   output logic [SLOT_FIELD_W-1:0] rsp_slot_number,
   output logic [SEQ_W-1:0]        rsp_sequence_number,
   output logic                    rsp_last,
   output logic                    rsp_rearm,
   output logic [TIME_FIELD_W-1:0] rsp_next_deadline,
   output logic                    rsp_deadline_valid
);

   cmd_type    cmd;
   status_type status;

   tqm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy)
   );

   tqm_datapath #(
      .SLOTS     (SLOTS),
      .TIME_BITS (TIME_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_opcode          (req_opcode),
      .req_cancel_slot     (req_cancel_slot),
      .req_cancel_sequence (req_cancel_sequence),
      .req_expire_at       (req_expire_at),
      .req_repeat_interval (req_repeat_interval),
      .req_now_time        (req_now_time),
      .rsp_strobe          (rsp_strobe),
      .rsp_result_kind     (rsp_result_kind),
      .rsp_slot_number     (rsp_slot_number),
      .rsp_sequence_number (rsp_sequence_number),
      .rsp_last            (rsp_last),
      .rsp_rearm           (rsp_rearm),
      .rsp_next_deadline   (rsp_next_deadline),
      .rsp_deadline_valid  (rsp_deadline_valid)
   );

endmodule

// ===== verif/timer_queue_manager_test.sv =====
// Self-checking testbench for timer_queue_manager: directed and random add, cancel and tick
// words are checked against a timer table kept alongside the block.
// Depends on tqm_pkg and the timer_queue_manager RTL.
`timescale 1ns / 1ps

module timer_queue_manager_test;
   import tqm_pkg::*;

   localparam int NSLOT = 64;
   localparam logic [47:0] TMAX = '1;

   typedef struct {
      logic [KIND_W-1:0] kind;
      logic [5:0]        slot;
      logic [31:0]       seqn;
      logic              last;
      logic              rearm;
      logic [47:0]       deadline;
      logic              dvalid;
   } timer_event_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_opcode = OP_NONE;
   logic [5:0]  req_cancel_slot = '0;
   logic [31:0] req_cancel_sequence = '0;
   logic [47:0] req_expire_at = '0;
   logic [47:0] req_repeat_interval = '0;
   logic [47:0] req_now_time = '0;
   logic        rsp_strobe;
   logic [KIND_W-1:0] rsp_result_kind;
   logic [5:0]  rsp_slot_number;
   logic [31:0] rsp_sequence_number;
   logic        rsp_last;
   logic        rsp_rearm;
   logic [47:0] rsp_next_deadline;
   logic        rsp_deadline_valid;

   logic [47:0] shadow_expiry [NSLOT];
   logic [47:0] shadow_reload [NSLOT];
   logic [31:0] shadow_seq [NSLOT];
   bit          shadow_active [NSLOT];
   logic [31:0] shadow_next_seq;

   timer_event_t pending_events[$];
   int          error_count = 0;
   int          sender_idle_pct = 0;
   logic [47:0] wall_time = 48'd100;

   timer_queue_manager uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
      $display("%0t: mismatch on %s: got %0h, expected %0h", $time, field, got, want);
      error_count++;
   endtask

   function automatic bit find_earliest(output logic [47:0] t);
      bit any;
      any = 0;
      t = '0;
      for (int i = 0; i < NSLOT; i++)
         if (shadow_active[i] && (!any || shadow_expiry[i] < t)) begin
            t = shadow_expiry[i];
            any = 1;
         end
      return any;
   endfunction

   task automatic predict_timers(input logic [1:0] op, input logic [5:0] cslot,
                                 input logic [31:0] cseq, input logic [47:0] when,
                                 input logic [47:0] intv, input logic [47:0] now);
      timer_event_t rows[$];
      timer_event_t r;
      bit rearm_flag, any, due [NSLOT];
      logic [47:0] first, dl;
      logic [48:0] sum;
      int free_slot, pick;
      rearm_flag = 0;
      r = '{default: '0};
      if (op == OP_ADD) begin
         free_slot = -1;
         for (int i = NSLOT - 1; i >= 0; i--)
            if (!shadow_active[i]) free_slot = i;
         if (free_slot < 0) begin
            r.kind = KIND_FULL;
         end else begin
            any = find_earliest(first);
            rearm_flag = !any || when < first;
            shadow_expiry[free_slot] = when;
            shadow_reload[free_slot] = intv;
            shadow_seq[free_slot] = shadow_next_seq;
            shadow_active[free_slot] = 1;
            r.kind = KIND_ADDED;
            r.slot = 6'(free_slot);
            r.seqn = shadow_next_seq;
            shadow_next_seq++;
         end
         rows.push_back(r);
      end else if (op == OP_CANCEL) begin
         r.kind = KIND_NOT_FOUND;
         if (shadow_active[cslot] && shadow_seq[cslot] == cseq) begin
            shadow_active[cslot] = 0;
            r.kind = KIND_CANCELLED;
         end
         r.slot = cslot;
         r.seqn = cseq;
         rows.push_back(r);
      end else if (op == OP_TICK) begin
         for (int i = 0; i < NSLOT; i++) due[i] = shadow_active[i] && shadow_expiry[i] <= now;
         while (rows.size() < RESULT_CAP) begin
            pick = -1;
            for (int i = 0; i < NSLOT; i++)
               if (due[i] && (pick < 0 || shadow_expiry[i] < shadow_expiry[pick])) pick = i;
            if (pick < 0) break;
            due[pick] = 0;
            r.kind = KIND_EXPIRED;
            r.slot = 6'(pick);
            r.seqn = shadow_seq[pick];
            rows.push_back(r);
            if (shadow_reload[pick] != 0) begin
               sum = {1'b0, now} + {1'b0, shadow_reload[pick]};
               shadow_expiry[pick] = sum[48] ? TMAX : sum[47:0];
            end else begin
               shadow_active[pick] = 0;
            end
         end
         if (rows.size() == 0) begin
            r.kind = KIND_NOTHING;
            rows.push_back(r);
         end
         rearm_flag = find_earliest(dl);
      end
      any = find_earliest(dl);
      foreach (rows[k]) begin
         rows[k].last = (k == rows.size() - 1);
         rows[k].rearm = rearm_flag;
         rows[k].deadline = any ? dl : '0;
         rows[k].dvalid = any;
         pending_events.push_back(rows[k]);
      end
   endtask

   always @(negedge clock) begin
      timer_event_t e;
      if (!reset && rsp_strobe) begin
         if (pending_events.size() == 0) begin
            $display("%0t: result word arrived with nothing expected", $time);
            error_count++;
         end else begin
            e = pending_events.pop_front();
            if (rsp_result_kind !== e.kind)
               report("result_kind", 64'(rsp_result_kind), 64'(e.kind));
            if (rsp_slot_number !== e.slot)
               report("slot_number", 64'(rsp_slot_number), 64'(e.slot));
            if (rsp_sequence_number !== e.seqn)
               report("sequence_number", 64'(rsp_sequence_number), 64'(e.seqn));
            if (rsp_last !== e.last) report("last", 64'(rsp_last), 64'(e.last));
            if (rsp_rearm !== e.rearm) report("rearm", 64'(rsp_rearm), 64'(e.rearm));
            if (rsp_next_deadline !== e.deadline)
               report("next_deadline", 64'(rsp_next_deadline), 64'(e.deadline));
            if (rsp_deadline_valid !== e.dvalid)
               report("deadline_valid", 64'(rsp_deadline_valid), 64'(e.dvalid));
         end
      end
   end

   function automatic logic [47:0] rand48();
      return 48'({$urandom(), $urandom()});
   endfunction

   // Called at a rising edge; returns at the rising edge where the word is taken.
   task automatic send_word(input logic [1:0] op, input logic [5:0] cslot,
                            input logic [31:0] cseq, input logic [47:0] when,
                            input logic [47:0] intv, input logic [47:0] now);
      bit taken;
      if ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start <= 1'b1;
      req_opcode <= op;
      req_cancel_slot <= cslot;
      req_cancel_sequence <= cseq;
      req_expire_at <= when;
      req_repeat_interval <= intv;
      req_now_time <= now;
      do begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end while (!taken);
      predict_timers(op, cslot, cseq, when, intv, now);
   endtask

   task automatic send_add(input logic [47:0] when, input logic [47:0] intv);
      send_word(OP_ADD, 6'($urandom()), $urandom(), when, intv, rand48());
   endtask

   task automatic send_cancel(input logic [5:0] cslot, input logic [31:0] cseq);
      send_word(OP_CANCEL, cslot, cseq, rand48(), rand48(), rand48());
   endtask

   task automatic send_tick(input logic [47:0] now);
      send_word(OP_TICK, 6'($urandom()), $urandom(), rand48(), rand48(), now);
   endtask

   task automatic test_basic_operations();
      send_tick(48'd0);
      send_add(48'd500, 48'd0);
      send_add(48'd300, 48'd1000);
      send_add(48'd300, 48'd0);
      send_add(TMAX, TMAX);
      send_add(48'd0, 48'd0);
      send_cancel(6'd0, 32'd1);
      send_cancel(6'd0, 32'd0);
      send_cancel(6'd63, 32'hFFFF_FFFF);
      send_word(OP_NONE, '1, '1, TMAX, TMAX, TMAX);
      send_tick(48'd299);
      send_tick(48'd300);
      send_tick(48'd1300);
      send_tick(TMAX - 48'd5);
      send_tick(TMAX);
      send_tick(TMAX);
      send_cancel(6'd3, 32'd3);
      send_tick(TMAX);
   endtask

   task automatic test_full_table();
      for (int i = 0; i < NSLOT; i++)
         send_add(48'($urandom_range(0, 40)), $urandom_range(0, 1) ? 48'd0 : 48'd50);
      send_add(48'd0, 48'd0);
      send_tick(48'd40);
      send_tick(48'd100);
      for (int i = 0; i < NSLOT; i++)
         if (shadow_active[i]) send_cancel(6'(i), shadow_seq[i]);
      wall_time = 48'd100;
   endtask

   task automatic random_word();
      int sel, s;
      logic [47:0] intv;
      sel = $urandom_range(99);
      if (sel < 40) begin
         intv = $urandom_range(0, 1) ? 48'd0 : 48'($urandom_range(1, 2000));
         if ($urandom_range(19) == 0) send_add(rand48(), rand48());
         else send_add(wall_time + 48'($urandom_range(0, 3000)), intv);
      end else if (sel < 65) begin
         s = $urandom_range(NSLOT - 1);
         for (int i = 0; i < NSLOT && !shadow_active[s]; i++) s = (s + 1) % NSLOT;
         if ($urandom_range(4) != 0) send_cancel(6'(s), shadow_seq[s]);
         else send_cancel(6'($urandom()), $urandom());
      end else if (sel < 97) begin
         wall_time += 48'($urandom_range(0, 1500));
         send_tick(wall_time);
      end else begin
         send_word(OP_NONE, 6'($urandom()), $urandom(), rand48(), rand48(), rand48());
      end
   endtask

   task automatic test_random_traffic(input int idle_pct, input int words);
      sender_idle_pct = idle_pct;
      repeat (words) random_word();
      sender_idle_pct = 0;
   endtask

   initial begin
      shadow_next_seq = '0;
      for (int i = 0; i < NSLOT; i++) shadow_active[i] = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_operations();
      test_full_table();
      test_random_traffic(7, 18);
      test_random_traffic(58, 18);
      test_random_traffic(0, 17);
      start <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #30ms;
      $display("simulation failed");
      $finish;
   end

endmodule
